>>> design/rxsort_pkg.sv
// Shared constants, record type and datapath command type for the record exchange sort.
package rxsort_pkg;

	localparam int MAX_RECORDS = 64;
	localparam int ADDR_W      = $clog2(MAX_RECORDS);
	localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
	localparam int ID_W        = 31;
	localparam int SAL_W       = 32;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [SAL_W-1:0] salary;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef enum logic [2:0] {
		OP_NONE,
		OP_STORE_IN,
		OP_LOAD_CUR,
		OP_CMP_SWAP,
		OP_WRITE_CUR,
		OP_LOAD_OUT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [ADDR_W-1:0] waddr;
		logic [ADDR_W-1:0] raddr;
		logic              last;
		logic              ovf;
	} cmd_t;

endpackage

>>> design/record_exchange_sort_descending.sv
// Record exchange sort, descending by salary: top level joining controller and datapath.
// Records arrive on the rec channel, one word per cycle, while the block is loading.
// The store holds 64 records; a record that arrives when it is full is dropped and the
// overflow bit is raised on every word of the following output run.
// The word with end_of_set high closes the set. rec_stall then rises and stays high
// until the last word of the output run has been taken.
// The exchange sort is paced by the single read port of the store: each comparison
// needs a read step and then a compare step on the fetched record.
// The sorted run then leaves on the res channel, highest salary first, with last_of_run
// on the final word. Each word is read, loaded and then held for the receiver;
// a stalled word is held unchanged in the output register.
// Ties leave the sort in the order that the exchange sequence produces.
// After the run the record count and the overflow flag clear and loading resumes.
// Reset returns the block to loading with an empty set; the store needs no clearing.
module record_exchange_sort_descending
	import rxsort_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rec_valid,
	output logic             rec_stall,
	input  logic [ID_W-1:0]  worker_id,
	input  logic [SAL_W-1:0] salary_cents,
	input  logic             end_of_set,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [ID_W-1:0]  sorted_id,
	output logic [SAL_W-1:0] sorted_salary,
	output logic             last_of_run,
	output logic             overflow
);

	cmd_t cmd;

	rxsort_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec_valid  (rec_valid),
		.rec_stall  (rec_stall),
		.end_of_set (end_of_set),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.cmd        (cmd)
	);

	rxsort_dp u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.worker_id     (worker_id),
		.salary_cents  (salary_cents),
		.sorted_id     (sorted_id),
		.sorted_salary (sorted_salary),
		.last_of_run   (last_of_run),
		.overflow      (overflow)
	);

	a_no_load_during_run: assert property (@(posedge clk) disable iff (!arst_n)
		!rec_stall |-> !res_valid)
		else $error("record accepted while a result is pending");

	a_resume_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && last_of_run |=> !rec_stall)
		else $error("loading did not resume after the last word");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !last_of_run |=> rec_stall)
		else $error("loading resumed before the run ended");

	a_end_starts_sort: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_stall && end_of_set |=> rec_stall)
		else $error("end of set did not start the sort");

endmodule

>>> design/rxsort_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rxsort_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/rxsort_ctrl.sv
// Controller state machine: loading, exchange sort sequencing and the output run.
module rxsort_ctrl
	import rxsort_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic rec_valid,
	output logic rec_stall,
	input  logic end_of_set,
	output logic res_valid,
	input  logic res_stall,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_LOAD,
		S_RD_I,
		S_LD_I,
		S_RD_J,
		S_CMP_J,
		S_WR_I,
		S_RD_OUT,
		S_LD_OUT,
		S_HOLD_OUT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  n_q;
	logic              dropped_q;
	logic              valid_q;
	logic              last_q;
	logic [ADDR_W-1:0] i_q;
	logic [ADDR_W-1:0] j_q;
	logic [ADDR_W-1:0] k_q;

	logic             stored;
	logic [CNT_W-1:0] n_next;
	logic             accept;
	logic             j_end;
	logic             i_end;
	logic             k_end;

	assign stored = count_q < CNT_W'(MAX_RECORDS);
	assign n_next = count_q + CNT_W'(stored);
	assign accept = (state_q == S_LOAD) && rec_valid;
	assign j_end  = (CNT_W'(j_q) + CNT_W'(1)) == n_q;
	assign i_end  = (CNT_W'(i_q) + CNT_W'(2)) == n_q;
	assign k_end  = (CNT_W'(k_q) + CNT_W'(1)) == n_q;

	assign rec_stall = (state_q != S_LOAD);
	assign res_valid = valid_q;

	always_comb begin
		cmd       = '0;
		cmd.op    = OP_NONE;
		cmd.last  = k_end;
		cmd.ovf   = dropped_q;
		case (state_q)
			S_LOAD: begin
				cmd.waddr = count_q[ADDR_W-1:0];
				if (rec_valid && stored) begin
					cmd.op = OP_STORE_IN;
				end
			end
			S_RD_I: cmd.raddr = i_q;
			S_LD_I: cmd.op = OP_LOAD_CUR;
			S_RD_J: cmd.raddr = j_q;
			S_CMP_J: begin
				cmd.op    = OP_CMP_SWAP;
				cmd.waddr = j_q;
			end
			S_WR_I: begin
				cmd.op    = OP_WRITE_CUR;
				cmd.waddr = i_q;
			end
			S_RD_OUT: cmd.raddr = k_q;
			S_LD_OUT: cmd.op = OP_LOAD_OUT;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			count_q   <= '0;
			n_q       <= '0;
			dropped_q <= 1'b0;
			valid_q   <= 1'b0;
			last_q    <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						count_q <= n_next;
						if (!stored) begin
							dropped_q <= 1'b1;
						end
						if (end_of_set) begin
							n_q <= n_next;
							i_q <= '0;
							k_q <= '0;
							if (n_next >= CNT_W'(2)) begin
								state_q <= S_RD_I;
							end else begin
								state_q <= S_RD_OUT;
							end
						end
					end
				end
				S_RD_I: state_q <= S_LD_I;
				S_LD_I: begin
					j_q     <= i_q + ADDR_W'(1);
					state_q <= S_RD_J;
				end
				S_RD_J: state_q <= S_CMP_J;
				S_CMP_J: begin
					if (j_end) begin
						state_q <= S_WR_I;
					end else begin
						j_q     <= j_q + ADDR_W'(1);
						state_q <= S_RD_J;
					end
				end
				S_WR_I: begin
					if (i_end) begin
						k_q     <= '0;
						state_q <= S_RD_OUT;
					end else begin
						i_q     <= i_q + ADDR_W'(1);
						state_q <= S_RD_I;
					end
				end
				S_RD_OUT: state_q <= S_LD_OUT;
				S_LD_OUT: begin
					valid_q <= 1'b1;
					last_q  <= k_end;
					state_q <= S_HOLD_OUT;
				end
				S_HOLD_OUT: begin
					if (!res_stall) begin
						valid_q <= 1'b0;
						if (last_q) begin
							count_q   <= '0;
							dropped_q <= 1'b0;
							state_q   <= S_LOAD;
						end else begin
							k_q     <= k_q + ADDR_W'(1);
							state_q <= S_RD_OUT;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

>>> design/rxsort_dp.sv
// Datapath: record store, held record with salary comparator, and output register.
module rxsort_dp
	import rxsort_pkg::*;
(
	input  logic             clk,
	input  cmd_t             cmd,
	input  logic [ID_W-1:0]  worker_id,
	input  logic [SAL_W-1:0] salary_cents,
	output logic [ID_W-1:0]  sorted_id,
	output logic [SAL_W-1:0] sorted_salary,
	output logic             last_of_run,
	output logic             overflow
);

	rec_t cur_q;
	rec_t out_q;
	logic last_q;
	logic ovf_q;
	rec_t rdata;
	rec_t wdata;
	logic we;
	logic greater;

	assign greater = rdata.salary > cur_q.salary;

	always_comb begin
		we    = 1'b0;
		wdata = cur_q;
		case (cmd.op)
			OP_STORE_IN: begin
				we    = 1'b1;
				wdata = '{id: worker_id, salary: salary_cents};
			end
			OP_CMP_SWAP:  we = greater;
			OP_WRITE_CUR: we = 1'b1;
			default:      we = 1'b0;
		endcase
	end

	rxsort_ram #(
		.WIDTH (REC_W),
		.DEPTH (MAX_RECORDS)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (cmd.waddr),
		.wdata (wdata),
		.raddr (cmd.raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD_CUR: cur_q <= rdata;
			OP_CMP_SWAP: begin
				if (greater) begin
					cur_q <= rdata;
				end
			end
			OP_LOAD_OUT: begin
				out_q  <= rdata;
				last_q <= cmd.last;
				ovf_q  <= cmd.ovf;
			end
			default: cur_q <= cur_q;
		endcase
	end

	assign sorted_id     = out_q.id;
	assign sorted_salary = out_q.salary;
	assign last_of_run   = last_q;
	assign overflow      = ovf_q;

endmodule
